// File: sv/periodic_timer_set_top_assert.svh
// Assertion macros shared by the timer set RTL.
`ifndef PERIODIC_TIMER_SET_TOP_ASSERT_SVH
`define PERIODIC_TIMER_SET_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("periodic timer set: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("periodic timer set: next-cycle check failed");

`endif

// File: sv/ptmr_pkg.sv
`timescale 1ns / 1ps
package ptmr_pkg;

   // Operation codes carried on the request channel.
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_INIT  = 3'd1;
   localparam logic [2:0] FUNC_START = 3'd2;
   localparam logic [2:0] FUNC_STOP  = 3'd3;
   localparam logic [2:0] FUNC_SETC  = 3'd4;
   localparam logic [2:0] FUNC_READ  = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_COUNT   = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;

   localparam logic [30:0] MAX_PERIOD_RESET = 31'h7FFF_FFFF;

   // One timer entry as kept in the entry memory.
   typedef struct packed {
      logic        running;
      logic [30:0] period;
      logic [31:0] expire;
      logic [31:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // What the update unit decides for one entry.
   typedef struct packed {
      logic        wr;
      logic        due;
      logic        status;
      logic [31:0] count;
      entry_type   entry;
   } upd_type;

endpackage

// File: sv/ptmr_ram.sv
`timescale 1ns / 1ps
module ptmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: sv/ptmr_upd.sv
`timescale 1ns / 1ps
module ptmr_upd (
   input  logic [2:0]         func,
   input  logic               sel_ok,
   input  ptmr_pkg::entry_type entry,
   input  logic [31:0]        now,
   input  logic [31:0]        value,
   input  logic [30:0]        max_period,
   output ptmr_pkg::upd_type  upd
);
   import ptmr_pkg::*;

   logic [31:0] diff;
   logic [31:0] sum;
   logic        due;
   logic        bad_period;

   // One adder serves both the reload on expiry and the first expiry on start.
   assign sum        = ((func == FUNC_TICK) ? entry.expire : now) + {1'b0, entry.period};
   assign diff       = entry.expire - now;
   assign due        = entry.running && ((diff == 32'd0) || diff[31]);
   assign bad_period = (value == 32'd0) || (value > {1'b0, max_period});

   always_comb begin
      upd        = '0;
      upd.entry  = entry;
      case (func)
         FUNC_TICK: begin
            if (due) begin
               upd.due          = 1'b1;
               upd.wr           = 1'b1;
               upd.entry.expire = sum;
               upd.entry.count  = entry.count + 32'd1;
               upd.count        = entry.count + 32'd1;
            end
         end
         FUNC_INIT: begin
            if (sel_ok) begin
               if (bad_period) begin
                  upd.status = 1'b1;
               end else begin
                  upd.wr            = 1'b1;
                  upd.entry.period  = value[30:0];
                  upd.entry.expire  = '0;
                  upd.entry.count   = '0;
                  upd.entry.running = 1'b0;
               end
            end
         end
         FUNC_START: begin
            if (sel_ok) begin
               if (entry.period == '0) begin
                  upd.status = 1'b1;
               end else if (!entry.running) begin
                  upd.wr            = 1'b1;
                  upd.entry.running = 1'b1;
                  upd.entry.expire  = sum;
               end
            end
         end
         FUNC_STOP: begin
            if (sel_ok) begin
               upd.wr            = 1'b1;
               upd.entry.running = 1'b0;
            end
         end
         FUNC_SETC: begin
            if (sel_ok) begin
               upd.wr          = 1'b1;
               upd.entry.count = value;
            end
         end
         FUNC_READ: begin
            upd.count = sel_ok ? entry.count : 32'd0;
         end
         default: begin
            upd.wr = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/periodic_timer_set_top.sv
`timescale 1ns / 1ps
// Periodic timer set: NUM_TIMERS periodic timers that share one 32-bit tick count.
// Requests arrive on the req_ stream; the operation travels in req_tuser and the
// timer index and value in req_tdata. Results leave on the rsp_ stream with the
// result kind in rsp_tuser and rsp_tlast marking the final result of a request.
// The csr_ port writes the largest period that init accepts.
// An init, start, stop, set count or read count transaction first reads the timer
// entry from the entry memory, then updates it and loads the result register. In a
// tick the update unit visits one entry per cycle unless the scan stalls, and a
// final flush state releases the last expiry with rsp_tlast set.
// A tick whose timers are not due gives no result at all. The block takes one
// transaction at a time, and req_tready is high only while it waits for a request.
// When the receiver stalls, the result register holds its transaction and the
// tick scan stops on a due timer while an expiry is pending, until the register
// frees up; no result is lost or repeated. Reset is synchronous and clears the
// tick count, the period limit (to its largest value) and every entry's valid bit,
// so all timers read as stopped, uninitialized and with a zero count right after reset.
`include "periodic_timer_set_top_assert.svh"
module periodic_timer_set_top #(
   parameter int NUM_TIMERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] timer_sel, [34:3] value, rest zero
   input  logic [2:0]  req_tuser,   // [2:0] func
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] timer_out, [34:3] count_out, [35] status
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data  // max_period
);
   import ptmr_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SLOTS = 1 << IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_OP    = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic [31:0]      now_ff, now_in;
   logic [30:0]      max_period_ff;
   logic [SLOTS-1:0] vld_ff, vld_in;

   // The request being worked on.
   logic [2:0]  func_ff, func_in;
   logic [2:0]  sel_ff, sel_in;
   logic [31:0] value_ff, value_in;
   logic        sel_ok_ff, sel_ok_in;

   // An expiry found by the scan but not yet known to be the last one.
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [31:0]      pend_count_ff, pend_count_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [2:0]  out_timer_ff, out_timer_in;
   logic [31:0] out_count_ff, out_count_in;
   logic        out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;
   logic        out_load;
   logic        out_free;

   logic [IDX_W-1:0]   rd_addr;
   logic               ram_we;
   logic [ENTRY_W-1:0] ram_q;
   entry_type          entry_rd;
   upd_type            upd;
   logic [IDX_W-1:0]   req_idx;
   logic               req_sel_ok;

   ptmr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_idx_ff),
      .wr_data (upd.entry),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // An entry never written reads as the reset entry.
   assign entry_rd = vld_ff[cur_idx_ff] ? entry_type'(ram_q) : '0;

   ptmr_upd u_upd (
      .func       (func_ff),
      .sel_ok     (sel_ok_ff),
      .entry      (entry_rd),
      .now        (now_ff),
      .value      (value_ff),
      .max_period (max_period_ff),
      .upd        (upd)
   );

   assign req_idx    = IDX_W'(req_tdata[2:0]);
   assign req_sel_ok = (32'(req_tdata[2:0]) < 32'(NUM_TIMERS));
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cur_idx_in    = cur_idx_ff;
      now_in        = now_ff;
      vld_in        = vld_ff;
      func_in       = func_ff;
      sel_in        = sel_ff;
      value_in      = value_ff;
      sel_ok_in     = sel_ok_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      pend_count_in = pend_count_ff;
      out_load      = 1'b0;
      out_kind_in   = out_kind_ff;
      out_timer_in  = out_timer_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      rd_addr       = cur_idx_ff;
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // The entry read starts in the accepting cycle.
            rd_addr = (req_tuser == FUNC_TICK) ? '0 : req_idx;
            if (req_tvalid) begin
               func_in   = req_tuser;
               sel_in    = req_tdata[2:0];
               value_in  = req_tdata[34:3];
               sel_ok_in = req_sel_ok;
               if (req_tuser == FUNC_TICK) begin
                  now_in     = now_ff + 32'd1;
                  cur_idx_in = '0;
                  state_in   = S_SCAN;
               end else begin
                  cur_idx_in = req_idx;
                  state_in   = S_OP;
               end
            end
         end
         S_OP: begin
            if (out_free) begin
               ram_we        = upd.wr;
               out_load      = 1'b1;
               out_kind_in   = (func_ff == FUNC_READ) ? KIND_COUNT : KIND_ACK;
               out_timer_in  = sel_ff;
               out_count_in  = upd.count;
               out_status_in = upd.status;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            // A due timer with an expiry already pending waits for the result
            // register; the current entry is then read again unchanged.
            if (!(upd.due && pend_vld_ff && !out_free)) begin
               if (upd.due) begin
                  ram_we = 1'b1;
                  if (pend_vld_ff) begin
                     out_load      = 1'b1;
                     out_kind_in   = KIND_EXPIRED;
                     out_timer_in  = 3'(pend_idx_ff);
                     out_count_in  = pend_count_ff;
                     out_status_in = 1'b0;
                     out_last_in   = 1'b0;
                  end
                  pend_vld_in   = 1'b1;
                  pend_idx_in   = cur_idx_ff;
                  pend_count_in = upd.count;
               end
               if (cur_idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end else begin
                  cur_idx_in = cur_idx_ff + IDX_W'(1);
                  rd_addr    = cur_idx_ff + IDX_W'(1);
               end
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_kind_in   = KIND_EXPIRED;
               out_timer_in  = 3'(pend_idx_ff);
               out_count_in  = pend_count_ff;
               out_status_in = 1'b0;
               out_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_we) begin
         vld_in[cur_idx_ff] = 1'b1;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_idx_ff    <= '0;
         now_ff        <= '0;
         max_period_ff <= MAX_PERIOD_RESET;
         vld_ff        <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_idx_ff    <= cur_idx_in;
         now_ff        <= now_in;
         vld_ff        <= vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            max_period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      sel_ff        <= sel_in;
      value_ff      <= value_in;
      sel_ok_ff     <= sel_ok_in;
      pend_idx_ff   <= pend_idx_in;
      pend_count_ff <= pend_count_in;
      out_kind_ff   <= out_kind_in;
      out_timer_ff  <= out_timer_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_status_ff, out_count_ff, out_timer_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // An expiry is held back only while a tick is being worked on.
   `PTS_ASSERT_IMPL(a_ready_no_pend, clock, reset, req_tready, !pend_vld_ff)
   // The entry memory is written only while an entry is being updated.
   `PTS_ASSERT_IMPL(a_wr_busy, clock, reset, ram_we, (state_ff == S_OP) || (state_ff == S_SCAN))
   // A tick transaction starts the scan at the first timer.
   `PTS_ASSERT_NEXT(a_tick_scan, clock, reset, req_tvalid && req_tready && (req_tuser == FUNC_TICK), (state_ff == S_SCAN) && (cur_idx_ff == '0))
   // The scan never runs past the last timer.
   `PTS_ASSERT_IMPL(a_scan_idx, clock, reset, state_ff == S_SCAN, cur_idx_ff <= LAST_IDX)

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for periodic_timer_set_top.
//
// Requests are driven on the req_ stream in bursts of random length with
// random gaps between them. Every accepted request is fed to a behavioral
// model of the timer set that lives in this file, and the model appends the
// results the request should cause to a queue. A separate process takes every
// accepted result transaction off the rsp_ stream and compares it, field by
// field, with the oldest queued result. The receiver stalls on a rotating
// random pattern, and on request it holds off for a long stretch so that the
// block fills up and stalls its input.
//
// The run is a sequence of test tasks: directed corner cases, period limit
// checks across several max_period settings, a back-pressure test with every
// timer expiring on every tick, and random traffic in several phases with
// different idling and register settings. The period register is written only
// while the block is idle, after every queued result has arrived and the
// block has had time to finish a tick that causes no result.
module tb_top;
   import ptmr_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int NUM_TIMERS = 8;
   // A tick visits every entry; allow generous slack on top of that.
   localparam int TICK_LATENCY = NUM_TIMERS + 2;
   localparam int SETTLE_CYCLES = 4 * TICK_LATENCY;
   // Cycles the receiver holds off during the back-pressure test.
   localparam int LONG_HOLD_CYCLES = 300;
   // Cycles without any transaction on either stream before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_ERROR_LINES = 40;

   // Operation codes that the block does not define; it must acknowledge them and leave every timer unchanged.
   localparam logic [2:0] FUNC_RSVD_LO = 3'd6;
   localparam logic [2:0] FUNC_RSVD_HI = 3'd7;

   // One result as it should appear on the rsp_ stream.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  timer;
      logic [31:0] count;
      logic        status;
      logic        last;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;

   // Expected results, oldest first.
   timer_result_type expected_results[$];
   int error_count = 0;

   // Behavioral copy of the timer set.
   logic [30:0] limit_period;
   logic [31:0] tick_now;
   logic [30:0] period_tab[NUM_TIMERS];
   logic [31:0] expire_tab[NUM_TIMERS];
   logic [31:0] count_tab[NUM_TIMERS];
   logic        running_tab[NUM_TIMERS];

   // Sender idling controls.
   int burst_left = 0;
   int gap_max = 0;

   // Receiver controls. The test tasks raise hold_asked; the receiver process
   // alone advances hold_served when it starts a long hold.
   bit rsp_quiet = 1'b1;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   logic [15:0] ready_pattern = 16'hFFFF;
   int pattern_step = 0;

   int quiet_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   periodic_timer_set_top #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_ERROR_LINES) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Puts the behavioral timer set into its reset state.
   function automatic void clear_timer_model();
      limit_period = MAX_PERIOD_RESET;
      tick_now = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         period_tab[i] = '0;
         expire_tab[i] = '0;
         count_tab[i] = '0;
         running_tab[i] = 1'b0;
      end
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [2:0] timer,
                                       input logic [31:0] count, input logic status,
                                       input logic last);
      timer_result_type r;
      r.kind = kind;
      r.timer = timer;
      r.count = count;
      r.status = status;
      r.last = last;
      expected_results.push_back(r);
   endfunction

   // Applies one accepted request to the model and queues the results it causes.
   function automatic void predict_timer_results(input logic [2:0] func,
                                                 input logic [2:0] sel,
                                                 input logic [31:0] value);
      logic        known;
      logic        status;
      logic [31:0] diff;
      int          hits;
      known = (int'(sel) < NUM_TIMERS);
      status = 1'b0;
      hits = 0;
      if (func == FUNC_TICK) begin
         tick_now = tick_now + 32'd1;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (running_tab[i]) begin
               diff = expire_tab[i] - tick_now;
               // Due when the signed distance to the expiry is zero or negative.
               if (diff == 32'd0 || diff[31]) begin
                  expire_tab[i] = expire_tab[i] + {1'b0, period_tab[i]};
                  count_tab[i] = count_tab[i] + 32'd1;
                  push_result(KIND_EXPIRED, 3'(i), count_tab[i], 1'b0, 1'b0);
                  hits++;
               end
            end
         end
         if (hits > 0) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
         end
      end else if (func == FUNC_READ) begin
         push_result(KIND_COUNT, sel, known ? count_tab[sel] : 32'd0, 1'b0, 1'b1);
      end else begin
         if (known) begin
            case (func)
               FUNC_INIT: begin
                  if (value == 32'd0 || value > {1'b0, limit_period}) begin
                     status = 1'b1;
                  end else begin
                     period_tab[sel] = value[30:0];
                     expire_tab[sel] = '0;
                     count_tab[sel] = '0;
                     running_tab[sel] = 1'b0;
                  end
               end
               FUNC_START: begin
                  if (period_tab[sel] == '0) begin
                     status = 1'b1;
                  end else if (!running_tab[sel]) begin
                     running_tab[sel] = 1'b1;
                     expire_tab[sel] = tick_now + {1'b0, period_tab[sel]};
                  end
               end
               FUNC_STOP: begin
                  running_tab[sel] = 1'b0;
               end
               FUNC_SETC: begin
                  count_tab[sel] = value;
               end
               default: begin
               end
            endcase
         end
         push_result(KIND_ACK, sel, 32'd0, status, 1'b1);
      end
   endfunction

   // Offers one request and returns at the edge where it is accepted. The
   // sender works in bursts; a gap may be inserted before a new burst.
   task automatic send_request(input logic [2:0] func, input logic [2:0] sel,
                               input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if (gap_max > 0) begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {5'd0, value, sel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer_results(func, sel, value);
      burst_left--;
   endtask

   // Stops offering requests until every expected result has arrived, then
   // gives a tick without results time to finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes max_period; only called while the block is idle.
   task automatic write_max_period(input logic [30:0] limit);
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      limit_period = limit;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Corner cases of every operation, the value extremes and both ends of the
   // timer index.
   task automatic test_directed_ops();
      send_request(FUNC_READ, 3'd0, 32'hFFFF_FFFF);      // count right after reset
      send_request(FUNC_START, 3'd1, 32'd0);             // start without a period
      send_request(FUNC_INIT, 3'd2, 32'd0);              // zero period is rejected
      send_request(FUNC_INIT, 3'd2, 32'hFFFF_FFFF);      // above the limit
      send_request(FUNC_INIT, 3'd2, 32'h7FFF_FFFF);      // exactly the limit
      send_request(FUNC_INIT, 3'd3, 32'd1);
      send_request(FUNC_START, 3'd3, 32'd0);
      send_request(FUNC_START, 3'd3, 32'd0);             // start while running
      send_request(FUNC_STOP, 3'd5, 32'd0);              // stop while stopped
      send_request(FUNC_SETC, 3'd4, 32'hFFFF_FFFF);      // set count while uninitialized
      send_request(FUNC_INIT, 3'd4, 32'd1);
      send_request(FUNC_SETC, 3'd4, 32'hFFFF_FFFF);      // count wraps on next expiry
      send_request(FUNC_START, 3'd4, 32'd0);
      send_request(FUNC_INIT, 3'd0, 32'd2);
      send_request(FUNC_START, 3'd0, 32'd0);
      send_request(FUNC_INIT, 3'd7, 32'd1);
      send_request(FUNC_START, 3'd7, 32'd0);
      send_request(FUNC_TICK, 3'd7, 32'hFFFF_FFFF);
      send_request(FUNC_TICK, 3'd0, 32'd0);
      send_request(FUNC_RSVD_LO, 3'd7, 32'hFFFF_FFFF);   // undefined operations
      send_request(FUNC_RSVD_HI, 3'd0, 32'hFFFF_FFFF);
      send_request(FUNC_STOP, 3'd3, 32'd0);
      send_request(FUNC_TICK, 3'd0, 32'd0);
      send_request(FUNC_READ, 3'd4, 32'd0);
      send_request(FUNC_READ, 3'd7, 32'd0);
   endtask

   // Init against the smallest, zero and largest period limits.
   task automatic test_period_limits();
      wait_idle();
      write_max_period(31'd1);
      send_request(FUNC_INIT, 3'd0, 32'd1);
      send_request(FUNC_INIT, 3'd1, 32'd2);
      send_request(FUNC_START, 3'd1, 32'd0);
      wait_idle();
      // With a zero limit every period is rejected.
      write_max_period(31'd0);
      send_request(FUNC_INIT, 3'd2, 32'd1);
      send_request(FUNC_INIT, 3'd2, 32'd0);
      send_request(FUNC_READ, 3'd2, 32'd0);
      wait_idle();
      write_max_period(MAX_PERIOD_RESET);
      send_request(FUNC_INIT, 3'd2, 32'h8000_0000);
      send_request(FUNC_INIT, 3'd6, 32'h7FFF_FFFF);
      send_request(FUNC_START, 3'd6, 32'd0);
      wait_idle();
   endtask

   // Every timer expires on every tick while the receiver holds off, so the
   // result register stays full and the block must stall its request input.
   task automatic test_backpressure();
      rsp_quiet = 1'b0;
      gap_max = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         send_request(FUNC_INIT, 3'(i), 32'd1);
         send_request(FUNC_START, 3'(i), 32'd0);
      end
      hold_asked++;
      repeat (12) send_request(FUNC_TICK, 3'($urandom), $urandom);
      wait_idle();
   endtask

   // Random requests, mostly well formed with short periods so that expiries
   // are frequent, plus wild values and undefined operations.
   task automatic test_random_traffic();
      int pick;
      logic [2:0] func;
      logic [31:0] value;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               rsp_quiet = 1'b1;
               gap_max = 0;
               write_max_period(MAX_PERIOD_RESET);
            end
            1: begin
               rsp_quiet = 1'b0;
               gap_max = 6;
               write_max_period(31'd5);
            end
            2: begin
               rsp_quiet = 1'b0;
               gap_max = 3;
               write_max_period(31'($urandom_range(32'h7FFF_FFFF, 1)));
            end
            default: begin
               rsp_quiet = 1'b0;
               gap_max = 12;
               write_max_period(31'd1);
            end
         endcase
         // Bring most timers into the running state first.
         for (int i = 0; i < NUM_TIMERS; i++) begin
            send_request(FUNC_INIT, 3'(i), 32'($urandom_range(6, 1)));
            send_request(FUNC_START, 3'(i), $urandom);
         end
         repeat (9) begin
            pick = $urandom_range(99, 0);
            value = $urandom;
            if (pick < 40) begin
               func = FUNC_TICK;
            end else if (pick < 52) begin
               func = FUNC_INIT;
               value = 32'($urandom_range(8, 1));
            end else if (pick < 64) begin
               func = FUNC_START;
            end else if (pick < 70) begin
               func = FUNC_STOP;
            end else if (pick < 76) begin
               func = FUNC_SETC;
            end else if (pick < 90) begin
               func = FUNC_READ;
            end else if (pick < 95) begin
               func = $urandom_range(1, 0) ? FUNC_RSVD_HI : FUNC_RSVD_LO;
            end else begin
               func = FUNC_INIT;
            end
            send_request(func, 3'($urandom), value);
         end
      end
      // Leave the limit at its reset value.
      wait_idle();
      write_max_period(MAX_PERIOD_RESET);
   endtask

   // Receiver: a long hold when a test asks for one, otherwise a rotating
   // pattern that is redrawn once all of its 16 bits have been used.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ready_pattern[0];
         if (pattern_step == 15) begin
            pattern_step <= 0;
            case ($urandom_range(2, 0))
               0: ready_pattern <= 16'hFFFF;
               1: ready_pattern <= 16'($urandom | $urandom);
               default: ready_pattern <= 16'($urandom & $urandom);
            endcase
         end else begin
            pattern_step <= pattern_step + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %h, expected %h", name, got, want));
      end
   endtask

   // Compares each accepted result transaction with the oldest expected one.
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result, kind %0d timer %0d",
                                   rsp_tuser, rsp_tdata[2:0]));
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(rsp_tuser), 32'(want.kind));
            check_field("timer_out", 32'(rsp_tdata[2:0]), 32'(want.timer));
            check_field("count_out", rsp_tdata[34:3], want.count);
            check_field("status", 32'(rsp_tdata[35]), 32'(want.status));
            check_field("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   // Watchdog: abandons the run when no transaction moves on either stream
   // for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      clear_timer_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_period_limits();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      if (expected_results.size() != 0) begin
         report_error($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: periodic_timer_set_top.f
+incdir+sv
sv/ptmr_pkg.sv
sv/ptmr_ram.sv
sv/ptmr_upd.sv
sv/periodic_timer_set_top.sv
bench/tb_top.sv
